FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the scheduler block, used by its top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hdl/sjf_pkg.sv
// Types and constants shared by the shortest-remaining-time scheduler files.
package sjf_pkg;

    localparam int TIME_W = 16;
    localparam int SUM_W  = 24;
    localparam int JOB_W  = 4;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // One table entry; remaining time sits in the low bits.
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
    } job_t;

    // Result of one tick; the first field listed here lands in the highest bits.
    typedef struct packed {
        logic              all_done;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] finish_time;
        logic              job_finished;
        logic [JOB_W-1:0]  running_job;
        logic              idle;
        logic [TIME_W-1:0] tick_time;
    } result_t;

endpackage

FILE: hdl/sjf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sjf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sjf_sched.sv
// Scheduler core: job table in RAM, sequencer for load, clear and tick scans.
module sjf_sched import sjf_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  action_t             in_action,
    input  logic [TIME_W-1:0]   in_arrival,
    input  logic [TIME_W-1:0]   in_burst,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  job_count_reg, job_count_next;
    logic [CNT_W-1:0]  fin_count_reg, fin_count_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SUM_W-1:0]  sum_tat_reg, sum_tat_next;
    logic [SUM_W-1:0]  sum_wt_reg, sum_wt_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_arr_reg, best_arr_next;
    logic [TIME_W-1:0] best_bur_reg, best_bur_next;
    logic [TIME_W-1:0] best_rem_reg, best_rem_next;

    logic              accept;
    logic              issue;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    job_t              ram_wdata;
    job_t              ram_rdata;
    logic              candidate;
    logic              finish_write;

    logic [TIME_W-1:0] new_rem;
    logic              done;
    logic [TIME_W-1:0] fin_time;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [SUM_W:0]    tat_add;
    logic [SUM_W:0]    wt_add;
    logic [SUM_W-1:0]  tat_sat;
    logic [SUM_W-1:0]  wt_sat;

    sjf_ram #(
        .WIDTH ($bits(job_t)),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign accept = in_valid && in_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_action == ACT_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !pend_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready  = 1'b0;
        issue     = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_SCAN: issue     = (scan_reg != job_count_reg);
            ST_FIN:  res_valid = 1'b1;
            default: in_ready  = 1'b0;
        endcase
    end

    // Result arithmetic for the job chosen by the scan.
    always_comb begin
        new_rem  = best_rem_reg - 1'b1;
        done     = found_reg && (new_rem == '0);
        fin_time = now_reg + 1'b1;
        tat      = fin_time - best_arr_reg;
        wt       = tat - best_bur_reg;
        tat_add  = {1'b0, sum_tat_reg} + (SUM_W + 1)'(tat);
        wt_add   = {1'b0, sum_wt_reg} + (SUM_W + 1)'(wt);
        tat_sat  = tat_add[SUM_W] ? SUM_MAX : tat_add[SUM_W-1:0];
        wt_sat   = wt_add[SUM_W] ? SUM_MAX : wt_add[SUM_W-1:0];
    end

    assign finish_write = res_valid && res_ready;

    // Table write port: loads from idle, write-back of the served job at the end of a tick.
    // Reads and writes never overlap because one item is worked on at a time.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = job_count_reg[IDX_W-1:0];
        ram_wdata = '{arrival: in_arrival, burst: in_burst, remaining: in_burst};
        if (accept && in_action == ACT_LOAD && job_count_reg != CNT_MAX) begin
            ram_we = 1'b1;
        end else if (finish_write && found_reg) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = '{arrival: best_arr_reg, burst: best_bur_reg, remaining: new_rem};
        end
    end

    assign candidate = pend_reg && (ram_rdata.arrival <= now_reg)
                       && (ram_rdata.remaining != '0)
                       && (!found_reg || ram_rdata.remaining < best_rem_reg);

    always_comb begin
        job_count_next = job_count_reg;
        fin_count_next = fin_count_reg;
        now_next       = now_reg;
        sum_tat_next   = sum_tat_reg;
        sum_wt_next    = sum_wt_reg;
        scan_next      = scan_reg;
        pend_next      = issue;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_arr_next  = best_arr_reg;
        best_bur_next  = best_bur_reg;
        best_rem_next  = best_rem_reg;

        if (accept) begin
            unique case (in_action)
                ACT_LOAD: begin
                    if (job_count_reg != CNT_MAX) begin
                        job_count_next = job_count_reg + 1'b1;
                        if (in_burst == '0) begin
                            fin_count_next = fin_count_reg + 1'b1;
                        end
                    end
                end
                ACT_TICK: begin
                    scan_next  = '0;
                    found_next = 1'b0;
                end
                ACT_CLEAR: begin
                    job_count_next = '0;
                    fin_count_next = '0;
                    now_next       = '0;
                    sum_tat_next   = '0;
                    sum_wt_next    = '0;
                end
                ACT_NONE: begin
                    found_next = found_reg;
                end
            endcase
        end

        if (issue) begin
            scan_next = scan_reg + 1'b1;
        end

        if (candidate) begin
            found_next    = 1'b1;
            best_idx_next = pend_idx_reg;
            best_arr_next = ram_rdata.arrival;
            best_bur_next = ram_rdata.burst;
            best_rem_next = ram_rdata.remaining;
        end

        if (finish_write) begin
            now_next = fin_time;
            if (done) begin
                fin_count_next = fin_count_reg + 1'b1;
                sum_tat_next   = tat_sat;
                sum_wt_next    = wt_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            fin_count_reg <= '0;
            now_reg       <= '0;
            sum_tat_reg   <= '0;
            sum_wt_reg    <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            fin_count_reg <= fin_count_next;
            now_reg       <= now_next;
            sum_tat_reg   <= sum_tat_next;
            sum_wt_reg    <= sum_wt_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= scan_reg[IDX_W-1:0];
        best_idx_reg <= best_idx_next;
        best_arr_reg <= best_arr_next;
        best_bur_reg <= best_bur_next;
        best_rem_reg <= best_rem_next;
    end

    always_comb begin
        res.tick_time        = now_reg;
        res.idle             = !found_reg;
        res.running_job      = found_reg ? JOB_W'(best_idx_reg) : '0;
        res.job_finished     = done;
        res.finish_time      = done ? fin_time : '0;
        res.turnaround       = done ? tat : '0;
        res.waiting          = done ? wt : '0;
        res.total_turnaround = done ? tat_sat : sum_tat_reg;
        res.total_waiting    = done ? wt_sat : sum_wt_reg;
        res.all_done         = done ? ((fin_count_reg + 1'b1) == job_count_reg)
                                    : (fin_count_reg == job_count_reg);
    end

endmodule

FILE: hdl/preemptive_sjf_tick_scheduler_top.sv
// Load, clear and unused actions give no result transfer.
// A tick scans the loaded jobs from RAM, one read per cycle, and shows its result
// once the scan is through; the core takes no new input transfer until that result
// has been handed to the output register.
// Reset (aresetn low, synchronous) clears counts, time, totals and handshakes; table
// contents are left as they are and are only read after a load has written them.
module preemptive_sjf_tick_scheduler_top import sjf_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // arrival_time[15:0], burst_length[31:16]
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // tick_time[15:0], idle[16], running_job[20:17], job_finished[21],
    // finish_time[37:22], turnaround[53:38], waiting[69:54],
    // total_turnaround[93:70], total_waiting[117:94], all_done[118], zero[119]
    output logic [119:0] m_tdata
);

    `include "assert_macros.svh"

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // The core does the table work; it hands over a finished tick result once the
    // output register is empty or being emptied in the same cycle.
    sjf_sched #(
        .MAX_JOBS (MAX_JOBS)
    ) u_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (action_t'(s_tuser)),
        .in_arrival (s_tdata[15:0]),
        .in_burst   (s_tdata[31:16]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: it separates the result channel from the core, so the core
    // can take the next input transfer while a result still waits to be taken.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // The core never accepts input while it offers a tick result.
    `ASSERT_IMPLIES(a_no_accept_in_result, aclk, aresetn, s_tready, !res_valid)
    // An idle tick names no job and finishes none.
    `ASSERT_IMPLIES(a_idle_clean, aclk, aresetn, res_valid && res.idle,
        res.running_job == '0 && !res.job_finished)
    // A finishing job completes one tick after the tick it was served in.
    `ASSERT_IMPLIES(a_finish_time, aclk, aresetn, res_valid && res.job_finished,
        res.finish_time == TIME_W'(res.tick_time + 1'b1))
    // A result handed to an empty or draining output register shows up on the bus.
    `ASSERT_NEXT(a_result_shown, aclk, aresetn, res_valid && res_ready, m_tvalid)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the shortest-remaining-time-first tick scheduler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sjf_pkg::*;

    // Table size of the block under test; the predictor keeps a table of the same depth.
    localparam int JOB_SLOTS    = 16;
    // Lower bound on the load, tick and in-run clear transfers of the randomized job runs.
    localparam int RANDOM_ITEMS = 1200;
    // The receiver holds off once, for this many cycles, after this many results.
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    // Cycles allowed after the last result.
    localparam int TAIL_CYCLES  = 40;

    // One entry of the stimulus stream. A pause entry carries no transfer: the driver
    // holds its input back until every tick sent so far has returned its result.
    typedef struct {
        action_t     act;
        logic [15:0] arrival;
        logic [15:0] burst;
        bit          pause;
    } sched_op_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;      // arrival_time[15:0], burst_length[31:16]
    logic [1:0]   s_tuser  = ACT_NONE; // action[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // tick_time[15:0], idle[16], running_job[20:17], job_finished[21],
    // finish_time[37:22], turnaround[53:38], waiting[69:54],
    // total_turnaround[93:70], total_waiting[117:94], all_done[118], zero[119]
    logic [119:0] m_tdata;

    // Stimulus waiting to be driven, and tick results predicted but not yet seen.
    sched_op_t op_queue[$];
    result_t   expected_ticks[$];

    // Predictor state: the job table, the counts, the time counter and the totals.
    logic [15:0] tbl_arrival   [JOB_SLOTS];
    logic [15:0] tbl_burst     [JOB_SLOTS];
    logic [15:0] tbl_remaining [JOB_SLOTS];
    int          loaded_jobs = 0;
    int          done_jobs   = 0;
    logic [15:0] clock_now   = '0;
    logic [23:0] sum_tat     = '0;
    logic [23:0] sum_wt      = '0;

    // Bookkeeping. The accepted and received transfer counts, which other processes poll,
    // are updated with nonblocking assignments so that every reader sees the value of the last edge.
    int ops_total     = 0;   // transfers queued, pauses excluded
    int gen_ticks     = 0;   // tick transfers queued
    int ops_accepted  = 0;   // input transfers taken by the block
    int results_in    = 0;   // result transfers taken from the block
    int ticks_taken   = 0;   // driver-private tick count, includes the current edge
    int jobs_finished = 0;
    int idle_ticks    = 0;
    int fault_count   = 0;

    preemptive_sjf_tick_scheduler_top #(
        .MAX_JOBS (JOB_SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock; the first rising edge falls at 2 ns.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Adds to a 24-bit running total and sticks at the all-ones value.
    function automatic logic [23:0] sat_sum(logic [23:0] acc, logic [15:0] add);
        logic [24:0] s;
        s = {1'b0, acc} + {9'd0, add};
        return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[23:0];
    endfunction

    // Applies one accepted transfer to the predictor. A tick picks the arrived,
    // unfinished job with the least remaining time (lowest index on ties), serves it
    // for one tick, advances time and queues the expected result.
    function automatic void apply_op(sched_op_t op);
        result_t     r;
        int          best;
        int          i;
        logic        found;
        logic [15:0] t;
        r     = '0;
        best  = 0;
        found = 1'b0;
        t     = clock_now;
        case (op.act)
            ACT_LOAD: begin
                // A load into a full table is dropped.
                if (loaded_jobs < JOB_SLOTS) begin
                    tbl_arrival[loaded_jobs]   = op.arrival;
                    tbl_burst[loaded_jobs]     = op.burst;
                    tbl_remaining[loaded_jobs] = op.burst;
                    // A job with no work counts as finished the moment it is loaded.
                    if (op.burst == 16'd0) begin
                        done_jobs++;
                    end
                    loaded_jobs++;
                end
            end
            ACT_CLEAR: begin
                loaded_jobs = 0;
                done_jobs   = 0;
                clock_now   = '0;
                sum_tat     = '0;
                sum_wt      = '0;
            end
            ACT_TICK: begin
                for (i = 0; i < loaded_jobs; i++) begin
                    if (tbl_arrival[i] <= t && tbl_remaining[i] != 16'd0 &&
                        (!found || tbl_remaining[i] < tbl_remaining[best])) begin
                        found = 1'b1;
                        best  = i;
                    end
                end
                r.tick_time   = t;
                r.idle        = !found;
                r.running_job = found ? best[3:0] : 4'd0;
                if (found) begin
                    tbl_remaining[best] = tbl_remaining[best] - 16'd1;
                    if (tbl_remaining[best] == 16'd0) begin
                        // Finish, turnaround and waiting all wrap at 16 bits.
                        r.job_finished = 1'b1;
                        r.finish_time  = t + 16'd1;
                        r.turnaround   = r.finish_time - tbl_arrival[best];
                        r.waiting      = r.turnaround - tbl_burst[best];
                        done_jobs++;
                        sum_tat = sat_sum(sum_tat, r.turnaround);
                        sum_wt  = sat_sum(sum_wt, r.waiting);
                    end
                end
                clock_now          = t + 16'd1;
                r.total_turnaround = sum_tat;
                r.total_waiting    = sum_wt;
                // With nothing loaded the table counts as all done.
                r.all_done         = (done_jobs == loaded_jobs);
                expected_ticks.push_back(r);
            end
            default: begin
                // The unused action changes nothing.
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            fault_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    function automatic void push_op(action_t act, logic [15:0] arrival, logic [15:0] burst);
        op_queue.push_back('{act, arrival, burst, 1'b0});
        ops_total++;
        if (act == ACT_TICK) begin
            gen_ticks++;
        end
    endfunction

    // Queues a transfer whose data bits the block ignores; they are filled at random.
    function automatic void push_ctrl(action_t act);
        push_op(act, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    function automatic void push_pause();
        op_queue.push_back('{ACT_NONE, 16'd0, 16'd0, 1'b1});
    endfunction

    // Mostly short bursts so that jobs finish often; now and then a zero burst or a
    // full-range value that usually keeps its job busy for the rest of the run.
    function automatic logic [15:0] rand_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return 16'd0;
        end
        if (pick < 8) begin
            return 16'($urandom_range(0, 65535));
        end
        if (pick < 30) begin
            return 16'($urandom_range(7, 40));
        end
        return 16'($urandom_range(1, 6));
    endfunction

    // Driver. It offers the head of op_queue in bursts of random length with random
    // gaps between them. The predictor is updated at the edge where a transfer
    // completes, before the next item is chosen, so that a pause sees that tick.
    int        burst_left = 1;
    int        gap_left   = 0;
    sched_op_t cur_op;

    always @(posedge aclk) begin : drive_ops
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= ACT_NONE;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_op(cur_op);
                ops_accepted <= ops_accepted + 1;
                if (cur_op.act == ACT_TICK) begin
                    ticks_taken++;
                end
            end
            // A new item may go out only when the bus is empty or its item just left.
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_queue.size() != 0) begin
                    if (op_queue[0].pause) begin
                        // Hold back until every tick sent has come back.
                        if (ticks_taken == results_in) begin
                            void'(op_queue.pop_front());
                        end
                    end else begin
                        cur_op = op_queue.pop_front();
                        offer  = 1'b1;
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                                         $urandom_range(1, 6);
                        end else begin
                            burst_left--;
                        end
                    end
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {cur_op.burst, cur_op.arrival};
                    s_tuser <= cur_op.act;
                end
            end
        end
    end

    // Monitor. Every result transfer is unpacked into the package's result type and
    // compared field by field with the oldest prediction. The same process decides
    // m_tready: each stretch is at random fully ready or choppy, and one
    // long hold-off lets the block back up and stall its input.
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int mode_left  = 0;
    bit choppy     = 1'b0;

    always @(posedge aclk) begin : watch_results
        result_t got;
        result_t want;
        logic    rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[118:0];
                results_in <= results_in + 1;
                if (got.job_finished) begin
                    jobs_finished++;
                end
                if (got.idle) begin
                    idle_ticks++;
                end
                if (expected_ticks.size() == 0) begin
                    fault_count++;
                    $error("result transfer with no tick waiting for it");
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("tick_time", want.tick_time, got.tick_time);
                    check_field("idle", want.idle, got.idle);
                    check_field("running_job", want.running_job, got.running_job);
                    check_field("job_finished", want.job_finished, got.job_finished);
                    check_field("finish_time", want.finish_time, got.finish_time);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("waiting", want.waiting, got.waiting);
                    check_field("total_turnaround", want.total_turnaround,
                                got.total_turnaround);
                    check_field("total_waiting", want.total_waiting, got.total_waiting);
                    check_field("all_done", want.all_done, got.all_done);
                    check_field("pad bit", 24'd0, m_tdata[119]);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    choppy    = $urandom_range(0, 1);
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                rdy = choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // Stimulus and end of run.
    initial begin
        int          njobs;
        int          nticks;
        int          work;
        int          sel;
        int          k;
        int          waited;
        int          random_ops;
        logic [15:0] arr;
        logic [15:0] bur;
        logic [15:0] gen_now;

        // Directed part. A tick on the empty table is idle and all done.
        push_ctrl(ACT_TICK);
        // A zero-burst job is finished as soon as it is loaded and is never served.
        push_op(ACT_LOAD, 16'd0, 16'd0);
        push_ctrl(ACT_TICK);
        // Largest arrival and burst: this job never arrives within the run.
        push_op(ACT_LOAD, 16'hFFFF, 16'hFFFF);
        // Two equal jobs: the lower index wins the tie.
        push_op(ACT_LOAD, 16'd0, 16'd5);
        push_op(ACT_LOAD, 16'd0, 16'd5);
        push_ctrl(ACT_TICK);
        push_ctrl(ACT_TICK);
        // A short job arriving now preempts the job in service.
        push_op(ACT_LOAD, 16'd4, 16'd1);
        repeat (9) push_ctrl(ACT_TICK);
        // Everything that can run has finished, so this tick is idle.
        push_ctrl(ACT_TICK);
        push_ctrl(ACT_NONE);
        push_ctrl(ACT_CLEAR);
        push_pause();

        // Random part: job runs, each usually starting from a cleared table, with
        // enough ticks to finish the short jobs, plus stray loads, clears and
        // unused actions. Runs of more than sixteen loads hit the full table.
        gen_now    = '0;
        random_ops = 0;
        while (random_ops < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) != 0) begin
                push_ctrl(ACT_CLEAR);
                gen_now = '0;
            end
            njobs = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) :
                    $urandom_range(1, 16);
            work  = 0;
            for (k = 0; k < njobs; k++) begin
                sel = $urandom_range(0, 19);
                if (sel < 3) begin
                    arr = 16'($urandom_range(0, 65535));
                end else if (sel < 5) begin
                    arr = gen_now - 16'($urandom_range(0, 8));
                end else begin
                    arr = gen_now + 16'($urandom_range(0, 12));
                end
                bur = rand_burst();
                if (bur <= 16'd64) begin
                    work += bur;
                end
                push_op(ACT_LOAD, arr, bur);
                random_ops++;
            end
            nticks = work + $urandom_range(14, 20);
            if (nticks > 400) begin
                nticks = 400;
            end
            repeat (nticks) begin
                sel = $urandom_range(0, 199);
                if (sel < 6) begin
                    push_op(ACT_LOAD, gen_now + 16'($urandom_range(0, 4)), rand_burst());
                    random_ops++;
                end else if (sel < 9) begin
                    push_ctrl(ACT_NONE);
                end else if (sel == 9) begin
                    push_ctrl(ACT_CLEAR);
                    gen_now = '0;
                    random_ops++;
                end
                push_ctrl(ACT_TICK);
                gen_now = gen_now + 16'd1;
                random_ops++;
            end
            if ($urandom_range(0, 4) == 0) begin
                push_pause();
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted != ops_total) @(posedge aclk);
        waited = 0;
        while (results_in != gen_ticks && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_ticks.size() != 0) begin
            fault_count++;
            $error("%0d tick results never arrived", expected_ticks.size());
        end

        $display("Run: %0d input transfers, %0d ticks, %0d jobs finished, %0d idle ticks.",
                 ops_total, gen_ticks, jobs_finished, idle_ticks);
        $display("Ties, preemption, full table, zero bursts, clears and a %0d-cycle %s",
                 HOLD_CYCLES, "output hold-off were exercised.");
        if (fault_count == 0) begin
            $display("preemptive_sjf_tick_scheduler_top verification clean");
        end else begin
            $display("preemptive_sjf_tick_scheduler_top verification failed");
        end
        $finish;
    end

    // Watchdog: many times the slowest legal run of full-table ticks under stalls.
    initial begin
        #2000000;
        $display("preemptive_sjf_tick_scheduler_top verification failed");
        $finish;
    end

endmodule
